// File: rtl/core/gim_pkg.sv
// Shared types, widths and register codes of the Goertzel impedance meter.
package gim_pkg;

  localparam int FRAME_DEPTH_DEF = 1024;

  localparam int SAMPLE_W   = 12;
  localparam int COEF_W     = 16;
  localparam int COEF_FRAC  = 14;
  localparam int OHMS_W     = 24;
  localparam int OHMS_FRAC  = 16;
  localparam int IMP_W      = 24;
  localparam int FS_W       = 11;
  localparam int GZ_W       = 48;
  localparam int MEAN_W     = SAMPLE_W + 8;
  localparam int RE_W       = 50;
  localparam int ABS_W      = 49;
  localparam int SQ_W       = 100;
  localparam int MAG_W      = SQ_W / 2;
  localparam int DIV_W      = MAG_W + 1;
  localparam int STEP_W     = $clog2(DIV_W);
  localparam int SAT_BIT    = 40;
  localparam int SCALE_LO_W = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TWICE_COS = 2'd0,
    REG_COS       = 2'd1,
    REG_SIN       = 2'd2,
    REG_OHMS      = 2'd3
  } cfg_reg_t;

  localparam logic signed [COEF_W-1:0] TWICE_COS_RST = 16'sd0;
  localparam logic signed [COEF_W-1:0] COS_RST       = 16'sd0;
  localparam logic signed [COEF_W-1:0] SIN_RST       = 16'sd16384;
  localparam logic [OHMS_W-1:0]        OHMS_RST      = 24'd256272;

  typedef struct packed {
    logic load;
    logic div_start_mean;
    logic div_start_amp;
    logic div_step;
    logic mean_cap;
    logic gz_init;
    logic gz_mul;
    logic gz_add;
    logic fin_mul_re;
    logic fin_re;
    logic fin_mul_im;
    logic fin_im;
    logic sq_start_re;
    logic sq_start_im;
    logic sq_step;
    logic sqrt_start;
    logic sqrt_step;
    logic scale_lo;
    logic scale_hi;
    logic scale_fin;
    logic clear;
  } gim_cmd_t;

  typedef struct packed {
    logic gz_last;
  } gim_stat_t;

endpackage

// File: rtl/core/gim_sample_if.sv
// Sample channel: valid/ready handshake carrying one ADC sample.
interface gim_sample_if;
  logic                          valid;
  logic                          ready;
  logic [gim_pkg::SAMPLE_W-1:0]  sample;
  logic                          last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// File: rtl/core/gim_result_if.sv
// Result channel: valid/ready handshake carrying one impedance reading.
interface gim_result_if;
  logic                        valid;
  logic                        ready;
  logic [gim_pkg::IMP_W-1:0]   impedance_q8;
  logic [gim_pkg::FS_W-1:0]    frame_samples;

  modport source (output valid, output impedance_q8, output frame_samples, input ready);
  modport sink   (input valid, input impedance_q8, input frame_samples, output ready);
endinterface

// File: rtl/core/gim_datapath.sv
// Datapath: sample store, divider, Goertzel multiplier, squarer, root and scaler.
module gim_datapath #(
  parameter int FRAME_DEPTH = gim_pkg::FRAME_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  gim_pkg::gim_cmd_t                     cmd,
  output gim_pkg::gim_stat_t                    stat,
  input  logic [gim_pkg::SAMPLE_W-1:0]          sample,
  input  logic signed [gim_pkg::COEF_W-1:0]     twice_cosine,
  input  logic signed [gim_pkg::COEF_W-1:0]     cosine_term,
  input  logic signed [gim_pkg::COEF_W-1:0]     sine_term,
  input  logic [gim_pkg::OHMS_W-1:0]            ohms_per_count,
  output logic [gim_pkg::IMP_W-1:0]             impedance_q8,
  output logic [gim_pkg::FS_W-1:0]              frame_samples
);

  localparam int NW     = $clog2(FRAME_DEPTH + 1);
  localparam int AW     = $clog2(FRAME_DEPTH);
  localparam int SUM_W  = gim_pkg::SAMPLE_W + NW;
  localparam int PROD_W = gim_pkg::COEF_W + gim_pkg::GZ_W;
  localparam int REM_W  = gim_pkg::MAG_W + 2;
  localparam int HI_W   = gim_pkg::SAT_BIT - gim_pkg::SCALE_LO_W;
  localparam int FULL_W = gim_pkg::SAT_BIT + gim_pkg::OHMS_W;
  localparam int ZT_W   = FULL_W - gim_pkg::OHMS_FRAC;

  logic [gim_pkg::SAMPLE_W-1:0] store [FRAME_DEPTH];
  logic [gim_pkg::SAMPLE_W-1:0] rd;
  logic [NW-1:0]                count;
  logic [SUM_W-1:0]             sum;
  logic [NW-1:0]                idx;
  logic                         room;

  logic [gim_pkg::DIV_W-1:0]    dvd;
  logic [NW-1:0]                drem;
  logic [NW:0]                  drem_sh;
  logic                         dfit;
  logic [gim_pkg::MEAN_W-1:0]   mean;

  logic signed [gim_pkg::COEF_W-1:0] mul_a;
  logic signed [gim_pkg::GZ_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]          prod;
  logic signed [PROD_W-1:0]          prod_q14;
  logic signed [gim_pkg::GZ_W-1:0]   q1;
  logic signed [gim_pkg::GZ_W-1:0]   q2;
  logic signed [gim_pkg::GZ_W-1:0]   x;
  logic signed [gim_pkg::RE_W-1:0]   re;
  logic signed [gim_pkg::RE_W-1:0]   im;
  logic signed [gim_pkg::RE_W-1:0]   neg_re;
  logic signed [gim_pkg::RE_W-1:0]   neg_im;
  logic [gim_pkg::ABS_W-1:0]         abs_re;
  logic [gim_pkg::ABS_W-1:0]         abs_im;

  logic [gim_pkg::SQ_W-1:0]     mcand;
  logic [gim_pkg::ABS_W-1:0]    mplier;
  logic [gim_pkg::SQ_W-1:0]     acc;

  logic [gim_pkg::SQ_W-1:0]     rad;
  logic [gim_pkg::MAG_W-1:0]    root;
  logic [REM_W-1:0]             srem;
  logic [REM_W+1:0]             srem_sh;
  logic [REM_W+1:0]             trial;

  logic [2*gim_pkg::SCALE_LO_W-1:0]   plo;
  logic [HI_W+gim_pkg::OHMS_W-1:0]    phi;
  logic [FULL_W-1:0]                  full;
  logic [ZT_W-1:0]                    zt;
  logic                               big;

  assign room         = count < NW'(FRAME_DEPTH);
  assign stat.gz_last = idx == (count - NW'(1));

  // Frame capture.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      sum   <= '0;
    end else if (cmd.load && room) begin
      count <= count + NW'(1);
      sum   <= sum + SUM_W'(sample);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      store[count[AW-1:0]] <= sample;
    end
    if (cmd.gz_mul) begin
      rd <= store[idx[AW-1:0]];
    end
  end

  // Restoring divider by the sample count, one quotient bit a cycle.
  assign drem_sh = {drem, dvd[gim_pkg::DIV_W-1]};
  assign dfit    = drem_sh >= {1'b0, count};

  always_ff @(posedge clk) begin
    if (cmd.div_start_mean) begin
      dvd  <= gim_pkg::DIV_W'({sum, 8'b0});
      drem <= '0;
    end else if (cmd.div_start_amp) begin
      dvd  <= gim_pkg::DIV_W'({root, 1'b0});
      drem <= '0;
    end else if (cmd.div_step) begin
      if (dfit) begin
        drem <= NW'(drem_sh - {1'b0, count});
      end else begin
        drem <= drem_sh[NW-1:0];
      end
      dvd <= {dvd[gim_pkg::DIV_W-2:0], dfit};
    end
    if (cmd.mean_cap) begin
      mean <= dvd[gim_pkg::MEAN_W-1:0];
    end
  end

  // Shared coefficient multiplier.
  always_comb begin
    if (cmd.gz_mul) begin
      mul_a = twice_cosine;
      mul_b = q1;
    end else if (cmd.fin_mul_re) begin
      mul_a = cosine_term;
      mul_b = q2;
    end else begin
      mul_a = sine_term;
      mul_b = q2;
    end
  end

  assign prod_q14 = prod >>> gim_pkg::COEF_FRAC;
  assign x = $signed(gim_pkg::GZ_W'({rd, 8'b0})) - $signed(gim_pkg::GZ_W'(mean));

  always_ff @(posedge clk) begin
    if (cmd.gz_mul || cmd.fin_mul_re || cmd.fin_mul_im) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.gz_init) begin
      q1  <= '0;
      q2  <= '0;
      idx <= '0;
    end else if (cmd.gz_add) begin
      q1  <= prod_q14[gim_pkg::GZ_W-1:0] - q2 + x;
      q2  <= q1;
      idx <= idx + NW'(1);
    end
    if (cmd.fin_re) begin
      re <= gim_pkg::RE_W'(q1) - prod_q14[gim_pkg::RE_W-1:0];
    end
    if (cmd.fin_im) begin
      im <= prod_q14[gim_pkg::RE_W-1:0];
    end
  end

  assign neg_re = -re;
  assign neg_im = -im;
  assign abs_re = re[gim_pkg::RE_W-1] ? neg_re[gim_pkg::ABS_W-1:0] : re[gim_pkg::ABS_W-1:0];
  assign abs_im = im[gim_pkg::RE_W-1] ? neg_im[gim_pkg::ABS_W-1:0] : im[gim_pkg::ABS_W-1:0];

  // Shift-add squarer: re^2 then im^2 into one accumulator.
  always_ff @(posedge clk) begin
    if (cmd.sq_start_re) begin
      mcand  <= gim_pkg::SQ_W'(abs_re);
      mplier <= abs_re;
      acc    <= '0;
    end else if (cmd.sq_start_im) begin
      mcand  <= gim_pkg::SQ_W'(abs_im);
      mplier <= abs_im;
    end else if (cmd.sq_step) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[gim_pkg::SQ_W-2:0], 1'b0};
      mplier <= mplier >> 1;
    end
  end

  // Digit-by-digit square root, two radicand bits a cycle.
  assign srem_sh = {srem, rad[gim_pkg::SQ_W-1 -: 2]};
  assign trial   = (REM_W+2)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rad  <= acc;
      root <= '0;
      srem <= '0;
    end else if (cmd.sqrt_step) begin
      rad <= {rad[gim_pkg::SQ_W-3:0], 2'b00};
      if (srem_sh >= trial) begin
        srem <= REM_W'(srem_sh - trial);
        root <= {root[gim_pkg::MAG_W-2:0], 1'b1};
      end else begin
        srem <= srem_sh[REM_W-1:0];
        root <= {root[gim_pkg::MAG_W-2:0], 1'b0};
      end
    end
  end

  // Ohms scaling in two partial products, then saturate; a zero scale gives zero.
  assign big  = |dvd[gim_pkg::DIV_W-1:gim_pkg::SAT_BIT];
  assign full = {phi, {gim_pkg::SCALE_LO_W{1'b0}}} + FULL_W'(plo);
  assign zt   = full[FULL_W-1:gim_pkg::OHMS_FRAC];

  always_ff @(posedge clk) begin
    if (cmd.scale_lo) begin
      plo <= dvd[gim_pkg::SCALE_LO_W-1:0] * ohms_per_count;
    end
    if (cmd.scale_hi) begin
      phi <= dvd[gim_pkg::SAT_BIT-1:gim_pkg::SCALE_LO_W] * ohms_per_count;
    end
    if (cmd.scale_fin) begin
      if (ohms_per_count == '0) begin
        impedance_q8 <= '0;
      end else if (big || (|zt[ZT_W-1:gim_pkg::IMP_W])) begin
        impedance_q8 <= '1;
      end else begin
        impedance_q8 <= zt[gim_pkg::IMP_W-1:0];
      end
      frame_samples <= gim_pkg::FS_W'(count);
    end
  end

endmodule

// File: rtl/core/gim_controller.sv
// Controller: sequences capture, mean, recurrence, magnitude and scaling.
module gim_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               last_sample,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  gim_pkg::gim_stat_t stat,
  output gim_pkg::gim_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_LOAD, S_MEAN_START, S_MEAN_DIV, S_MEAN_CAP, S_GZ_MUL, S_GZ_ADD,
    S_RE_MUL, S_RE, S_IM_MUL, S_IM, S_SQ_RE_START, S_SQ_RE, S_SQ_IM_START,
    S_SQ_IM, S_SQRT_START, S_SQRT, S_AMP_START, S_AMP_DIV, S_SC_LO, S_SC_HI,
    S_SC_FIN, S_OUT
  } state_t;

  state_t                     state;
  logic [gim_pkg::STEP_W-1:0] cnt;

  assign in_ready  = state == S_LOAD;
  assign out_valid = state == S_OUT;

  always_comb begin
    cmd                = '0;
    cmd.load           = (state == S_LOAD) && in_valid;
    cmd.div_start_mean = state == S_MEAN_START;
    cmd.div_start_amp  = state == S_AMP_START;
    cmd.div_step       = (state == S_MEAN_DIV) || (state == S_AMP_DIV);
    cmd.mean_cap       = state == S_MEAN_CAP;
    cmd.gz_init        = state == S_MEAN_CAP;
    cmd.gz_mul         = state == S_GZ_MUL;
    cmd.gz_add         = state == S_GZ_ADD;
    cmd.fin_mul_re     = state == S_RE_MUL;
    cmd.fin_re         = state == S_RE;
    cmd.fin_mul_im     = state == S_IM_MUL;
    cmd.fin_im         = state == S_IM;
    cmd.sq_start_re    = state == S_SQ_RE_START;
    cmd.sq_start_im    = state == S_SQ_IM_START;
    cmd.sq_step        = (state == S_SQ_RE) || (state == S_SQ_IM);
    cmd.sqrt_start     = state == S_SQRT_START;
    cmd.sqrt_step      = state == S_SQRT;
    cmd.scale_lo       = state == S_SC_LO;
    cmd.scale_hi       = state == S_SC_HI;
    cmd.scale_fin      = state == S_SC_FIN;
    cmd.clear          = (state == S_OUT) && out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          cnt <= '0;
          if (in_valid && last_sample) state <= S_MEAN_START;
        end
        S_MEAN_START: state <= S_MEAN_DIV;
        S_MEAN_DIV: begin
          cnt <= cnt + gim_pkg::STEP_W'(1);
          if (cnt == gim_pkg::STEP_W'(gim_pkg::DIV_W - 1)) begin
            cnt   <= '0;
            state <= S_MEAN_CAP;
          end
        end
        S_MEAN_CAP: state <= S_GZ_MUL;
        S_GZ_MUL:   state <= S_GZ_ADD;
        S_GZ_ADD:   state <= stat.gz_last ? S_RE_MUL : S_GZ_MUL;
        S_RE_MUL:   state <= S_RE;
        S_RE:       state <= S_IM_MUL;
        S_IM_MUL:   state <= S_IM;
        S_IM:       state <= S_SQ_RE_START;
        S_SQ_RE_START: state <= S_SQ_RE;
        S_SQ_RE: begin
          cnt <= cnt + gim_pkg::STEP_W'(1);
          if (cnt == gim_pkg::STEP_W'(gim_pkg::ABS_W - 1)) begin
            cnt   <= '0;
            state <= S_SQ_IM_START;
          end
        end
        S_SQ_IM_START: state <= S_SQ_IM;
        S_SQ_IM: begin
          cnt <= cnt + gim_pkg::STEP_W'(1);
          if (cnt == gim_pkg::STEP_W'(gim_pkg::ABS_W - 1)) begin
            cnt   <= '0;
            state <= S_SQRT_START;
          end
        end
        S_SQRT_START: state <= S_SQRT;
        S_SQRT: begin
          cnt <= cnt + gim_pkg::STEP_W'(1);
          if (cnt == gim_pkg::STEP_W'(gim_pkg::MAG_W - 1)) begin
            cnt   <= '0;
            state <= S_AMP_START;
          end
        end
        S_AMP_START: state <= S_AMP_DIV;
        S_AMP_DIV: begin
          cnt <= cnt + gim_pkg::STEP_W'(1);
          if (cnt == gim_pkg::STEP_W'(gim_pkg::DIV_W - 1)) begin
            cnt   <= '0;
            state <= S_SC_LO;
          end
        end
        S_SC_LO:  state <= S_SC_HI;
        S_SC_HI:  state <= S_SC_FIN;
        S_SC_FIN: state <= S_OUT;
        S_OUT: begin
          if (out_ready) state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

// File: rtl/core/goertzel_impedance_meter_core.sv
// Top level of the single-bin Goertzel impedance meter.
// Samples of a frame transfer in at one per cycle while the block is loading; up to
// FRAME_DEPTH are stored and the rest are dropped, while the sample marked last still
// closes the frame. After the marked sample the input stalls while the block works: a
// restoring divide for the mean, then the recurrence through the shared 16x48
// coefficient multiplier (a multiply and an add step per stored sample), the real and
// imaginary parts, shift-add squaring of each, bit-pair square root, another divide
// for the amplitude and the scaling (low and high partial products, then saturation).
// The result holds on the output until it transfers, and the next frame loads after
// that.
// Registers are written through wr_en/wr_index/wr_data and act from the next frame on;
// write them only while no frame is in flight.
module goertzel_impedance_meter_core #(
  parameter int FRAME_DEPTH = gim_pkg::FRAME_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  gim_sample_if.sink                        sample_in,
  gim_result_if.source                      result_out,
  input  logic                              wr_en,
  input  logic [gim_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [gim_pkg::CFG_DATA_W-1:0]    wr_data
);

  gim_pkg::gim_cmd_t  cmd;
  gim_pkg::gim_stat_t stat;

  logic signed [gim_pkg::COEF_W-1:0] twice_cosine;
  logic signed [gim_pkg::COEF_W-1:0] cosine_term;
  logic signed [gim_pkg::COEF_W-1:0] sine_term;
  logic [gim_pkg::OHMS_W-1:0]        ohms_per_count;

  // Configuration registers; 16-bit ones keep the low bits of the write data.
  always_ff @(posedge clk) begin
    if (rst) begin
      twice_cosine   <= gim_pkg::TWICE_COS_RST;
      cosine_term    <= gim_pkg::COS_RST;
      sine_term      <= gim_pkg::SIN_RST;
      ohms_per_count <= gim_pkg::OHMS_RST;
    end else if (wr_en) begin
      unique case (gim_pkg::cfg_reg_t'(wr_index))
        gim_pkg::REG_TWICE_COS: twice_cosine   <= wr_data[gim_pkg::COEF_W-1:0];
        gim_pkg::REG_COS:       cosine_term    <= wr_data[gim_pkg::COEF_W-1:0];
        gim_pkg::REG_SIN:       sine_term      <= wr_data[gim_pkg::COEF_W-1:0];
        gim_pkg::REG_OHMS:      ohms_per_count <= wr_data[gim_pkg::OHMS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequence the frame.
  gim_controller u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (sample_in.valid),
    .last_sample (sample_in.last_sample),
    .in_ready    (sample_in.ready),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // Hold samples, run the arithmetic and drive the result payload.
  gim_datapath #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .sample         (sample_in.sample),
    .twice_cosine   (twice_cosine),
    .cosine_term    (cosine_term),
    .sine_term      (sine_term),
    .ohms_per_count (ohms_per_count),
    .impedance_q8   (result_out.impedance_q8),
    .frame_samples  (result_out.frame_samples)
  );

endmodule

// File: rtl/core/gim_checker.sv
// Port-level checks of the impedance meter, bound to the top level.
module gim_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gim_pkg::IMP_W-1:0]   impedance_q8
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(impedance_q8))
    else $error("result dropped or changed while stalled");

  a_no_load_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("sample taken while a result waits");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("result repeated after transfer");

endmodule

bind goertzel_impedance_meter_core gim_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (sample_in.ready),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .impedance_q8 (result_out.impedance_q8)
);

// File: test/tb.sv
// Self-checking testbench of the Goertzel impedance meter core.
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH      = gim_pkg::FRAME_DEPTH_DEF;
  // Longest stretch with no transfer: a full frame's processing plus a long stall.
  localparam int IDLE_LIMIT = 20000;
  // Cycles to let pass after the last result before a register write or the end.
  localparam int SETTLE     = 40;
  localparam int LONG_HOLD  = 400;

  typedef struct packed {
    logic [gim_pkg::IMP_W-1:0] impedance_q8;
    logic [gim_pkg::FS_W-1:0]  frame_samples;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                           wr_en    = 1'b0;
  logic [gim_pkg::CFG_IDX_W-1:0]  wr_index = '0;
  logic [gim_pkg::CFG_DATA_W-1:0] wr_data  = '0;

  gim_sample_if sample_ch ();
  gim_result_if result_ch ();

  goertzel_impedance_meter_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_ch.sink),
    .result_out (result_ch.source),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  always #5 clk = ~clk;

  // Predictor state: registers and the frame being collected.
  logic signed [gim_pkg::COEF_W-1:0] mdl_twice_cos;
  logic signed [gim_pkg::COEF_W-1:0] mdl_cos;
  logic signed [gim_pkg::COEF_W-1:0] mdl_sin;
  logic [gim_pkg::OHMS_W-1:0]        mdl_ohms;
  logic [gim_pkg::SAMPLE_W-1:0]      frame_store [DEPTH];
  int unsigned                       frame_count;
  longint unsigned                   frame_sum;

  reading_t expected_readings[$];
  int       mismatch_count;
  bit       send_gaps;    // sender idles at random when set
  bit       recv_gaps;    // receiver stalls at random when set
  bit       hold_req;     // toggle to ask the receiver for a long hold-off
  bit       hold_seen;
  int       hold_left;
  int       gap_left;
  int       quiet_cycles;

  function automatic longint wrap48(longint v);
    logic [gim_pkg::GZ_W-1:0] t;
    t = v[gim_pkg::GZ_W-1:0];
    return longint'($signed(t));
  endfunction

  // Mean removal, Goertzel pass, magnitude and scaling of the collected frame.
  function automatic reading_t impedance_of_frame();
    reading_t   r;
    longint     mean, coef, cc, ss, p1, p2, x, re, im;
    logic [127:0] ar, ai, sq, root, c, amp, z;
    mean = longint'((frame_sum << 8) / frame_count);
    coef = longint'(mdl_twice_cos);
    cc   = longint'(mdl_cos);
    ss   = longint'(mdl_sin);
    p1 = 0;
    p2 = 0;
    for (int i = 0; i < frame_count; i++) begin
      x  = (longint'(frame_store[i]) << 8) - mean;
      x  = ((coef * p1) >>> 14) - p2 + x;
      p2 = p1;
      p1 = wrap48(x);
    end
    re = p1 - ((p2 * cc) >>> 14);
    im = (p2 * ss) >>> 14;
    ar = (re < 0) ? 128'(-re) : 128'(re);
    ai = (im < 0) ? 128'(-im) : 128'(im);
    sq = ar * ar + ai * ai;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      c = root | (128'd1 << b);
      if (c * c <= sq) root = c;
    end
    amp = (2 * root) / frame_count;
    if (mdl_ohms == 0) z = '0;
    else if (amp >= (128'd1 << gim_pkg::SAT_BIT)) z = 128'hFFFFFF;
    else begin
      z = (amp * mdl_ohms) >> gim_pkg::OHMS_FRAC;
      if (z > 128'hFFFFFF) z = 128'hFFFFFF;
    end
    r.impedance_q8  = z[gim_pkg::IMP_W-1:0];
    r.frame_samples = frame_count[gim_pkg::FS_W-1:0];
    return r;
  endfunction

  // Advance the predictor by one accepted sample.
  function automatic void collect_sample(logic [gim_pkg::SAMPLE_W-1:0] s, logic last);
    if (frame_count < DEPTH) begin
      frame_store[frame_count] = s;
      frame_sum += s;
      frame_count++;
    end
    if (last) begin
      expected_readings.push_back(impedance_of_frame());
      frame_count = 0;
      frame_sum   = 0;
    end
  endfunction

  // Drive one sample; valid stays high across back-to-back transfers.
  task automatic send_sample(logic [gim_pkg::SAMPLE_W-1:0] s, logic last);
    int gap;
    gap = send_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.sample      <= s;
    sample_ch.last_sample <= last;
    do @(posedge clk); while (!sample_ch.ready);
    collect_sample(s, last);
  endtask

  task automatic send_frame(int len, int mode);
    logic [gim_pkg::SAMPLE_W-1:0] s;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: s = $urandom_range(0, 4095);
        1: s = (i % 2) ? 12'hFFF : 12'h000;
        default: s = 12'(2048 + $urandom_range(0, 800) - 400);
      endcase
      send_sample(s, i == len - 1);
    end
  endtask

  // Close the sender, then wait until every reading is in and the block is quiet.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(gim_pkg::cfg_reg_t idx, logic [gim_pkg::CFG_DATA_W-1:0] d);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= d;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      gim_pkg::REG_TWICE_COS: mdl_twice_cos = d[gim_pkg::COEF_W-1:0];
      gim_pkg::REG_COS:       mdl_cos       = d[gim_pkg::COEF_W-1:0];
      gim_pkg::REG_SIN:       mdl_sin       = d[gim_pkg::COEF_W-1:0];
      gim_pkg::REG_OHMS:      mdl_ohms      = d[gim_pkg::OHMS_W-1:0];
    endcase
  endtask

  // Upper data bits carry noise: the 16-bit registers must drop them.
  task automatic set_tone(int tc, int c, int s, int unsigned ohms);
    write_reg(gim_pkg::REG_TWICE_COS, {8'($urandom), 16'(tc)});
    write_reg(gim_pkg::REG_COS,       {8'($urandom), 16'(c)});
    write_reg(gim_pkg::REG_SIN,       {8'($urandom), 16'(s)});
    write_reg(gim_pkg::REG_OHMS,      24'(ohms));
  endtask

  // Receiver: check each reading, then stall at random or on a long hold.
  always @(posedge clk) begin
    reading_t got, want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left <= 0;
      gap_left  <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got.impedance_q8  = result_ch.impedance_q8;
        got.frame_samples = result_ch.frame_samples;
        if (expected_readings.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected reading: imp=%0d n=%0d", got.impedance_q8,
                     got.frame_samples);
        end else begin
          want = expected_readings.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("reading mismatch: imp exp=%0d act=%0d, n exp=%0d act=%0d",
                       want.impedance_q8, got.impedance_q8,
                       want.frame_samples, got.frame_samples);
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= LONG_HOLD;
        result_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        result_ch.ready <= 1'b0;
      end else if (result_ch.valid && result_ch.ready && recv_gaps) begin
        gap_left <= $urandom_range(0, 10);
        result_ch.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Extremes: lone 0 and 4095 samples, full-swing square wave, extreme registers.
  task automatic test_directed();
    send_gaps = 0;
    recv_gaps = 0;
    send_sample(12'h000, 1'b1);
    send_sample(12'hFFF, 1'b1);
    send_frame(8, 1);
    drain();
    set_tone(-32768, -16384, -16384, 24'hFFFFFF);
    send_frame(6, 1);
    send_sample(12'hFFF, 1'b1);
    drain();
    set_tone(32767, 16384, 16384, 0);
    send_frame(8, 1);
    drain();
    set_tone(0, 0, 16384, 24'hFFFFFF);
    send_frame(4, 0);
    drain();
  endtask

  // Random frames under a series of tone and scale settings, idling on and off.
  task automatic test_random_frames(int items);
    int sent, len;
    sent = 0;
    while (sent < items) begin
      send_gaps = $urandom_range(0, 3) != 0;
      recv_gaps = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 3))
        0: set_tone($urandom_range(0, 65535) - 32768, $urandom_range(0, 32768) - 16384,
                    $urandom_range(0, 32768) - 16384, $urandom_range(0, 24'hFFFFFF));
        1: set_tone(23170, 11585, 11585, $urandom_range(1, 600000));
        2: set_tone(-32768, -16384, 0, 24'hFFFFFF);
        default: set_tone(32767, 16384, 16384, $urandom_range(0, 1000));
      endcase
      repeat ($urandom_range(3, 8)) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 32);
        send_frame(len, $urandom_range(0, 2));
        sent += len;
      end
      drain();
    end
  endtask

  // A frame past the store depth; its marked sample is dropped but still ends it.
  task automatic test_overflow();
    send_gaps = 1;
    recv_gaps = 1;
    send_frame(DEPTH + 7, 0);
    drain();
  endtask

  // Receiver holds off while the sender keeps offering, so the input backs up.
  task automatic test_backpressure();
    send_gaps = 0;
    recv_gaps = 0;
    hold_req = ~hold_req;
    repeat (6) send_frame($urandom_range(1, 20), 0);
    drain();
    // Sender pauses until every reading is back between frames.
    send_gaps = 1;
    recv_gaps = 1;
    repeat (4) begin
      send_frame($urandom_range(1, 20), 2);
      drain();
    end
  endtask

  initial begin
    sample_ch.valid       <= 1'b0;
    sample_ch.sample      <= '0;
    sample_ch.last_sample <= 1'b0;
    mdl_twice_cos = gim_pkg::TWICE_COS_RST;
    mdl_cos       = gim_pkg::COS_RST;
    mdl_sin       = gim_pkg::SIN_RST;
    mdl_ohms      = gim_pkg::OHMS_RST;
    frame_count = 0;
    frame_sum   = 0;
    mismatch_count = 0;
    hold_req  = 0;
    hold_seen = 0;
    quiet_cycles = 0;
    send_gaps = 0;
    recv_gaps = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset register values first, then the rest.
    send_frame(16, 0);
    drain();
    test_directed();
    test_backpressure();
    test_overflow();
    test_random_frames(800);

    drain();
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/gim_pkg.sv
rtl/core/gim_sample_if.sv
rtl/core/gim_result_if.sv
rtl/core/gim_datapath.sv
rtl/core/gim_controller.sv
rtl/core/goertzel_impedance_meter_core.sv
rtl/core/gim_checker.sv
test/tb.sv
